[sv/tcd_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the threshold crossing discriminator.
package tcd_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int FRAME_SAMPLES = 8192;
	localparam int BIN_BITS      = $clog2(FRAME_SAMPLES);
	localparam int FRACTION_BITS = 8;
	localparam int FRAC_OUT_BITS = FRACTION_BITS + 1;
	localparam int DIFF_BITS     = SAMPLE_BITS + 1;
	localparam int STEP_BITS     = $clog2(FRAC_OUT_BITS);

	localparam logic [BIN_BITS-1:0] BIN_LAST = BIN_BITS'(FRAME_SAMPLES - 1);
	localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(FRAC_OUT_BITS - 1);

	// Queue between the classifier and the divider.
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_BITS  = $clog2(FIFO_DEPTH + 1);

	// Register map.
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_LEADING  = 1'b0;
	localparam logic REG_TRAILING = 1'b1;
	localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(7);

	// Edge codes.
	localparam logic EDGE_LEADING  = 1'b0;
	localparam logic EDGE_TRAILING = 1'b1;

	// One found crossing waiting for its interpolation.
	typedef struct packed {
		logic                 edge_kind;
		logic [BIN_BITS-1:0]  bin;
		logic [DIFF_BITS-1:0] num;
		logic [DIFF_BITS-1:0] den;
	} crossing_job_t;

endpackage

[sv/threshold_crossing_discriminator.sv]
`timescale 1ns / 1ps
// Top level of the threshold crossing discriminator with its register port.
//
// The sample channel (sample_valid/sample_ready, sample, first_of_frame) takes
// one waveform sample per transfer. The result channel (result_valid/
// result_ready, edge_kind, crossing_bin, crossing_fraction) gives one transfer
// for each leading or trailing threshold crossing found.
// Samples without a crossing are absorbed at one per cycle while the queue
// is not full. A crossing is placed into a four-entry job queue; the divider
// then picks it up and produces the 9-bit fraction, one quotient bit per
// cycle, except that the last step waits for a free output register. It
// takes the next crossing only after finishing the current one.
// When the receiver stalls, the finished result waits in the output register,
// the divider holds on its last step, the queue fills, and only then is
// sample_ready dropped.
// Reset clears the frame state, the queue and the output register and sets both
// thresholds to 7. The first sample after reset starts a frame. Thresholds
// are written through the APB-style port at byte addresses 0 and 4.
module threshold_crossing_discriminator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [tcd_pkg::ADDR_BITS-1:0]          paddr,
	input  logic [tcd_pkg::DATA_BITS-1:0]          pwdata,
	output logic [tcd_pkg::DATA_BITS-1:0]          prdata,
	output logic                                   pready,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic signed [tcd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   first_of_frame,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic                                   edge_kind,
	output logic [tcd_pkg::BIN_BITS-1:0]           crossing_bin,
	output logic [tcd_pkg::FRAC_OUT_BITS-1:0]      crossing_fraction
);
	import tcd_pkg::*;

	logic signed [SAMPLE_BITS-1:0] lead_thr_q;
	logic signed [SAMPLE_BITS-1:0] trail_thr_q;
	logic                          reg_sel;
	logic                          reg_write;

	logic                          job_push;
	logic                          job_full;
	logic                          job_pop;
	logic                          job_avail;
	crossing_job_t                 new_job;
	crossing_job_t                 head_job;

	// The register port always completes in its access cycle. Only the word
	// address bit selects a register.
	assign pready    = 1'b1;
	assign reg_sel   = paddr[2];
	assign reg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_thr_q  <= THRESHOLD_RESET;
			trail_thr_q <= THRESHOLD_RESET;
		end else if (reg_write) begin
			case (reg_sel)
				REG_LEADING:  lead_thr_q  <= pwdata[SAMPLE_BITS-1:0];
				REG_TRAILING: trail_thr_q <= pwdata[SAMPLE_BITS-1:0];
				default:      lead_thr_q  <= lead_thr_q;
			endcase
		end
	end

	// Reads return the stored 16-bit pattern in the low half of the word.
	always_comb begin
		case (reg_sel)
			REG_LEADING:  prdata = DATA_BITS'($unsigned(lead_thr_q));
			REG_TRAILING: prdata = DATA_BITS'($unsigned(trail_thr_q));
			default:      prdata = '0;
		endcase
	end

	// Front end: frames and crossings, one sample per cycle while queue has room.
	tcd_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.sample_valid       (sample_valid),
		.sample_ready       (sample_ready),
		.sample             (sample),
		.first_of_frame     (first_of_frame),
		.leading_threshold  (lead_thr_q),
		.trailing_threshold (trail_thr_q),
		.job_full           (job_full),
		.job_push           (job_push),
		.job                (new_job)
	);

	// Queue that lets the front end run ahead of the divider.
	tcd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (new_job),
		.full      (job_full),
		.pop       (job_pop),
		.not_empty (job_avail),
		.head_job  (head_job)
	);

	// Back end: interpolation of the crossing position.
	tcd_divider u_divider (
		.clk               (clk),
		.arst_n            (arst_n),
		.job_valid         (job_avail),
		.job               (head_job),
		.job_take          (job_pop),
		.result_valid      (result_valid),
		.result_ready      (result_ready),
		.edge_kind         (edge_kind),
		.crossing_bin      (crossing_bin),
		.crossing_fraction (crossing_fraction)
	);

endmodule

[sv/tcd_front.sv]
`timescale 1ns / 1ps
// Front end: accepts samples, tracks frame state and finds threshold crossings.
module tcd_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic signed [tcd_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                  first_of_frame,
	input  logic signed [tcd_pkg::SAMPLE_BITS-1:0] leading_threshold,
	input  logic signed [tcd_pkg::SAMPLE_BITS-1:0] trailing_threshold,
	input  logic                                  job_full,
	output logic                                  job_push,
	output tcd_pkg::crossing_job_t                job
);
	import tcd_pkg::*;

	logic signed [SAMPLE_BITS-1:0] prev_q;
	logic                          armed_q;
	logic [BIN_BITS-1:0]           bin_q;
	logic                          have_prev_q;

	logic                          accept;
	logic                          start;
	logic                          lead_hit;
	logic                          trail_hit;
	logic signed [DIFF_BITS-1:0]   prev_x;
	logic signed [DIFF_BITS-1:0]   cur_x;
	logic signed [DIFF_BITS-1:0]   tl_x;
	logic signed [DIFF_BITS-1:0]   tt_x;

	assign sample_ready = !job_full;
	assign accept       = sample_valid && sample_ready;
	assign start        = first_of_frame || !have_prev_q;

	assign prev_x = DIFF_BITS'(prev_q);
	assign cur_x  = DIFF_BITS'(sample);
	assign tl_x   = DIFF_BITS'(leading_threshold);
	assign tt_x   = DIFF_BITS'(trailing_threshold);

	assign lead_hit  = !armed_q && (prev_q < leading_threshold) && (sample >= leading_threshold);
	assign trail_hit = armed_q && (prev_q > trailing_threshold) && (sample <= trailing_threshold);

	always_comb begin
		job.bin = bin_q;
		if (armed_q) begin
			job.edge_kind = EDGE_TRAILING;
			job.num       = DIFF_BITS'(prev_x - tt_x);
			job.den       = DIFF_BITS'(prev_x - cur_x);
		end else begin
			job.edge_kind = EDGE_LEADING;
			job.num       = DIFF_BITS'(tl_x - prev_x);
			job.den       = DIFF_BITS'(cur_x - prev_x);
		end
	end

	assign job_push = accept && !start && (lead_hit || trail_hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			armed_q     <= 1'b0;
			bin_q       <= '0;
			have_prev_q <= 1'b0;
		end else if (accept) begin
			prev_q      <= sample;
			have_prev_q <= 1'b1;
			if (start) begin
				armed_q <= 1'b0;
				bin_q   <= '0;
			end else begin
				if (lead_hit || trail_hit) begin
					armed_q <= !armed_q;
				end
				if (bin_q != BIN_LAST) begin
					bin_q <= bin_q + 1'b1;
				end
			end
		end
	end

endmodule

[sv/tcd_fifo.sv]
`timescale 1ns / 1ps
// Short queue of crossing jobs between the front end and the divider.
module tcd_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tcd_pkg::crossing_job_t push_job,
	output logic                   full,
	input  logic                   pop,
	output logic                   not_empty,
	output tcd_pkg::crossing_job_t head_job
);
	import tcd_pkg::*;

	crossing_job_t              slots_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0]   wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0]   rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0]   count_q;
	logic                       do_push;
	logic                       do_pop;

	assign full      = (count_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = slots_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/tcd_divider.sv]
`timescale 1ns / 1ps
// Back end: restoring divider, one fraction bit per cycle; full output reg holds the last.
module tcd_divider (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 job_valid,
	input  tcd_pkg::crossing_job_t               job,
	output logic                                 job_take,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output logic                                 edge_kind,
	output logic [tcd_pkg::BIN_BITS-1:0]         crossing_bin,
	output logic [tcd_pkg::FRAC_OUT_BITS-1:0]    crossing_fraction
);
	import tcd_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                     state_q;
	logic [DIFF_BITS-1:0]     rem_q;
	logic [DIFF_BITS-1:0]     den_q;
	logic [FRAC_OUT_BITS-1:0] quo_q;
	logic [STEP_BITS-1:0]     step_q;
	logic                     kind_q;
	logic [BIN_BITS-1:0]      bin_q;

	logic                     out_valid_q;
	logic                     out_kind_q;
	logic [BIN_BITS-1:0]      out_bin_q;
	logic [FRAC_OUT_BITS-1:0] out_frac_q;

	logic [DIFF_BITS:0]       diff;
	logic                     ge;
	logic [DIFF_BITS-1:0]     rem_kept;
	logic                     out_free;
	logic                     advance;
	logic                     finish;

	assign diff     = {1'b0, rem_q} - {1'b0, den_q};
	assign ge       = !diff[DIFF_BITS];
	assign rem_kept = ge ? diff[DIFF_BITS-1:0] : rem_q;
	assign out_free = !out_valid_q || result_ready;
	assign advance  = (state_q == ST_DIV) && ((step_q != '0) || out_free);
	assign finish   = advance && (step_q == '0);
	assign job_take = (state_q == ST_IDLE) && job_valid;

	always_ff @(posedge clk) begin
		if (job_take) begin
			rem_q  <= job.num;
			den_q  <= job.den;
			kind_q <= job.edge_kind;
			bin_q  <= job.bin;
			quo_q  <= '0;
		end else if (advance) begin
			rem_q <= {rem_kept[DIFF_BITS-2:0], 1'b0};
			quo_q <= {quo_q[FRAC_OUT_BITS-2:0], ge};
		end
		if (finish) begin
			out_kind_q <= kind_q;
			out_bin_q  <= bin_q;
			out_frac_q <= {quo_q[FRAC_OUT_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (job_take) begin
						state_q <= ST_DIV;
						step_q  <= STEP_LAST;
					end
				end
				ST_DIV: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end else if (advance) begin
						step_q <= step_q - 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid      = out_valid_q;
	assign edge_kind         = out_kind_q;
	assign crossing_bin      = out_bin_q;
	assign crossing_fraction = out_frac_q;

endmodule
